// ----- sv/tfra_pkg.sv -----
package tfra_pkg;

	// Fixed field widths of the channels and registers
	localparam int FIELD_W     = 16;
	localparam int FACTOR_W    = 16;
	localparam int MODE_W      = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MODE_X     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MODE_Y     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_INCREASE_X = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_DECREASE_X = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_INCREASE_Y = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_DECREASE_Y = 3'd6;

	// Register reset values
	localparam logic [FIELD_W-1:0]  CAPACITY_RST = 16'd100;
	localparam logic [MODE_W-1:0]   MODE_RST     = 2'd1;
	localparam logic [FACTOR_W-1:0] INCREASE_RST = 16'd256;
	localparam logic [FACTOR_W-1:0] DECREASE_RST = 16'd512;

	// Mode bits: high bit selects multiplicative increase, low bit multiplicative decrease
	localparam int MODE_MI_BIT = 1;
	localparam int MODE_MD_BIT = 0;

	// Operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic eval;
		logic div_start;
		logic commit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic op_step;
		logic div_needed;
		logic div_busy;
	} sts_t;

endpackage

// ----- sv/tfra_if.sv -----
// Request channel: one item per load or step
interface tfra_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [tfra_pkg::FIELD_W-1:0] start_x;
	logic [tfra_pkg::FIELD_W-1:0] start_y;

	modport source(output valid, operation, start_x, start_y, input ready);
	modport sink(input valid, operation, start_x, start_y, output ready);
endinterface

// Result channel: rates after the item and the congestion flag
interface tfra_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tfra_pkg::FIELD_W-1:0] rate_x;
	logic [tfra_pkg::FIELD_W-1:0] rate_y;
	logic                        congested;

	modport source(output valid, rate_x, rate_y, congested, input ready);
	modport sink(input valid, rate_x, rate_y, congested, output ready);
endinterface

// ----- sv/tfra_divider.sv -----
// Restoring divider, one quotient bit per cycle
module tfra_divider #(
	parameter int DW = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [DW-1:0]                  dividend,
	input  logic [tfra_pkg::FACTOR_W-1:0]  divisor,
	output logic                           busy,
	output logic [DW-1:0]                  quotient,
	output logic                           rem_nonzero
);

	localparam int FW   = tfra_pkg::FACTOR_W;
	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   quo_q;
	logic [FW-1:0]   rem_q;
	logic [FW-1:0]   div_q;
	logic [FW:0]     trial;
	logic            ge;

	// Shift in the next dividend bit and try a subtraction
	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? FW'(trial - {1'b0, div_q}) : trial[FW-1:0];
		end
	end

	assign busy        = busy_q;
	assign quotient    = quo_q;
	assign rem_nonzero = (rem_q != '0);

endmodule

// ----- sv/tfra_datapath.sv -----
// Rate registers, configuration, multipliers, dividers and result register
module tfra_datapath #(
	parameter int RW = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tfra_pkg::cmd_t                    cmd,
	output tfra_pkg::sts_t                    sts,
	input  logic                              cfg_we,
	input  logic [tfra_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tfra_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              operation,
	input  logic [tfra_pkg::FIELD_W-1:0]      start_x,
	input  logic [tfra_pkg::FIELD_W-1:0]      start_y,
	output logic [tfra_pkg::FIELD_W-1:0]      rate_x,
	output logic [tfra_pkg::FIELD_W-1:0]      rate_y,
	output logic                              congested
);

	localparam int FLW = tfra_pkg::FIELD_W;
	localparam int FW  = tfra_pkg::FACTOR_W;
	localparam int MW  = tfra_pkg::MODE_W;
	localparam int DW  = RW + 8;
	localparam int PW  = RW + FW;
	localparam int LW  = (RW > FLW) ? RW : FLW;
	localparam logic [RW-1:0] RATE_MAX = '1;

	// Configuration registers
	logic [FLW-1:0] capacity_q;
	logic [MW-1:0]  mode_x_q, mode_y_q;
	logic [FW-1:0]  inc_x_q, dec_x_q, inc_y_q, dec_y_q;

	// Flow state
	logic [RW-1:0]  rate_x_q, rate_y_q;

	// Item and intermediate registers
	logic           op_q;
	logic [FLW-1:0] start_x_q, start_y_q;
	logic           cong_q;
	logic [PW-1:0]  prod_x_q, prod_y_q;

	// Result payload
	logic [FLW-1:0] out_x_q, out_y_q;
	logic           out_cong_q;

	logic           busy_x, busy_y;
	logic [DW-1:0]  quo_x, quo_y;
	logic           rnz_x, rnz_y;
	logic [LW:0]    rate_sum;
	logic [LW-1:0]  ext_x, ext_y;
	logic [RW-1:0]  load_x, load_y;
	logic [RW-1:0]  adj_x, adj_y;
	logic [RW-1:0]  next_x, next_y;

	// One adjustment by the flow's mode
	function automatic logic [RW-1:0] adjust_rate(
		input logic [RW-1:0] r,
		input logic [MW-1:0] mode,
		input logic [FW-1:0] inc,
		input logic [FW-1:0] dec,
		input logic          cong,
		input logic [PW-1:0] prod,
		input logic [DW-1:0] quo,
		input logic          rem_nz
	);
		logic [DW-1:0] mi_v;
		logic [RW:0]   ai_v;
		logic [DW:0]   md_v;
		logic [DW-1:0] sh;
		logic [DW-1:0] ad_v;
		logic [RW-1:0] res;
		mi_v = prod[PW-1:8];
		ai_v = {1'b0, r} + (RW+1)'(inc[FW-1:8]);
		md_v = {1'b0, quo} + (DW+1)'(rem_nz);
		sh   = {r, 8'b0};
		ad_v = (sh - DW'(dec)) >> 8;
		if (!cong) begin
			if (mode[tfra_pkg::MODE_MI_BIT]) begin
				if (mi_v == '0) begin
					res = RW'(1);
				end else if (mi_v[DW-1:RW] != '0) begin
					res = RATE_MAX;
				end else begin
					res = mi_v[RW-1:0];
				end
			end else begin
				res = ai_v[RW] ? RATE_MAX : ai_v[RW-1:0];
			end
		end else if (mode[tfra_pkg::MODE_MD_BIT]) begin
			if (dec == '0) begin
				res = r;
			end else if (md_v[DW:RW] != '0) begin
				res = RATE_MAX;
			end else begin
				res = md_v[RW-1:0];
			end
		end else begin
			res = (sh < DW'(dec)) ? '0 : ad_v[RW-1:0];
		end
		return res;
	endfunction

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= tfra_pkg::CAPACITY_RST;
			mode_x_q   <= tfra_pkg::MODE_RST;
			mode_y_q   <= tfra_pkg::MODE_RST;
			inc_x_q    <= tfra_pkg::INCREASE_RST;
			dec_x_q    <= tfra_pkg::DECREASE_RST;
			inc_y_q    <= tfra_pkg::INCREASE_RST;
			dec_y_q    <= tfra_pkg::DECREASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tfra_pkg::CFG_CAPACITY:   capacity_q <= cfg_data;
				tfra_pkg::CFG_MODE_X:     mode_x_q   <= cfg_data[MW-1:0];
				tfra_pkg::CFG_MODE_Y:     mode_y_q   <= cfg_data[MW-1:0];
				tfra_pkg::CFG_INCREASE_X: inc_x_q    <= cfg_data;
				tfra_pkg::CFG_DECREASE_X: dec_x_q    <= cfg_data;
				tfra_pkg::CFG_INCREASE_Y: inc_y_q    <= cfg_data;
				tfra_pkg::CFG_DECREASE_Y: dec_y_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item capture, then congestion check and products from the old rates
	assign rate_sum = (LW+1)'(rate_x_q) + (LW+1)'(rate_y_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			start_x_q <= start_x;
			start_y_q <= start_y;
		end
		if (cmd.eval) begin
			cong_q   <= (rate_sum > (LW+1)'(capacity_q));
			prod_x_q <= PW'(rate_x_q) * PW'(inc_x_q);
			prod_y_q <= PW'(rate_y_q) * PW'(inc_y_q);
		end
	end

	// One divider per flow for multiplicative decrease
	tfra_divider #(.DW(DW)) u_div_x (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cmd.div_start),
		.dividend    ({rate_x_q, 8'b0}),
		.divisor     (dec_x_q),
		.busy        (busy_x),
		.quotient    (quo_x),
		.rem_nonzero (rnz_x)
	);

	tfra_divider #(.DW(DW)) u_div_y (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cmd.div_start),
		.dividend    ({rate_y_q, 8'b0}),
		.divisor     (dec_y_q),
		.busy        (busy_y),
		.quotient    (quo_y),
		.rem_nonzero (rnz_y)
	);

	// Next rates: saturated start values on load, adjusted rates on step
	assign ext_x  = LW'(start_x_q);
	assign ext_y  = LW'(start_y_q);
	assign load_x = (ext_x > LW'(RATE_MAX)) ? RATE_MAX : RW'(ext_x);
	assign load_y = (ext_y > LW'(RATE_MAX)) ? RATE_MAX : RW'(ext_y);
	assign adj_x  = adjust_rate(rate_x_q, mode_x_q, inc_x_q, dec_x_q, cong_q,
		prod_x_q, quo_x, rnz_x);
	assign adj_y  = adjust_rate(rate_y_q, mode_y_q, inc_y_q, dec_y_q, cong_q,
		prod_y_q, quo_y, rnz_y);
	assign next_x = (op_q == tfra_pkg::OP_STEP) ? adj_x : load_x;
	assign next_y = (op_q == tfra_pkg::OP_STEP) ? adj_y : load_y;

	// Flow state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_x_q <= '0;
			rate_y_q <= '0;
		end else if (cmd.commit) begin
			rate_x_q <= next_x;
			rate_y_q <= next_y;
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_x_q    <= FLW'(next_x);
			out_y_q    <= FLW'(next_y);
			out_cong_q <= (op_q == tfra_pkg::OP_STEP) && cong_q;
		end
	end

	assign rate_x    = out_x_q;
	assign rate_y    = out_y_q;
	assign congested = out_cong_q;

	// Status
	assign sts.op_step    = (op_q == tfra_pkg::OP_STEP);
	assign sts.div_needed = cong_q &&
		((mode_x_q[tfra_pkg::MODE_MD_BIT] && (dec_x_q != '0)) ||
		 (mode_y_q[tfra_pkg::MODE_MD_BIT] && (dec_y_q != '0)));
	assign sts.div_busy   = busy_x || busy_y;

endmodule

// ----- sv/tfra_ctrl.sv -----
// Item sequencer and result valid flag
module tfra_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tfra_pkg::cmd_t cmd,
	input  tfra_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_START,
		ST_DIV,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Commands decoded from the state
	always_comb begin
		req_ready     = (state_q == ST_IDLE);
		cmd.capture   = (state_q == ST_IDLE) && req_valid;
		cmd.eval      = (state_q == ST_EVAL);
		cmd.div_start = (state_q == ST_START) && sts.div_needed;
		cmd.commit    = (state_q == ST_COMMIT) && (!out_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Result slot: set on commit, cleared when taken
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= sts.op_step ? ST_START : ST_COMMIT;
				end
				ST_START: begin
					state_q <= sts.div_needed ? ST_DIV : ST_COMMIT;
				end
				ST_DIV: begin
					if (!sts.div_busy) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

// ----- sv/two_flow_rate_adjust_step.sv -----
// Two flows sharing a link: load start rates or take one additive/multiplicative
// increase/decrease step, with congestion judged from the old rates.
// Channel req carries operation, start_x and start_y; channel rsp returns
// rate_x, rate_y and congested, one result per item. Registers are written
// through cfg_we / cfg_index / cfg_data; the user must write them only while
// the block is idle; the block itself does not enforce this. Items are
// handled one at a time. After acceptance a load item passes through EVAL
// and COMMIT; a step item passes through EVAL, START and COMMIT, with DIV
// between START and COMMIT when a division is needed. The division uses
// the restoring divider of each flow, which produces one quotient bit per
// cycle over RATE_WIDTH + 8 bits.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls, the following item holds in its final
// state until the result register frees up.
// Reset clears both rates to zero and puts the registers at their defaults.
module two_flow_rate_adjust_step #(
	parameter int RATE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tfra_req_if.sink                          req,
	tfra_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [tfra_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tfra_pkg::CFG_DATA_W-1:0]   cfg_data
);

	tfra_pkg::cmd_t cmd;
	tfra_pkg::sts_t sts;

	tfra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tfra_datapath #(.RW(RATE_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.operation (req.operation),
		.start_x   (req.start_x),
		.start_y   (req.start_y),
		.rate_x    (rsp.rate_x),
		.rate_y    (rsp.rate_y),
		.congested (rsp.congested)
	);

`ifndef SYNTHESIS
	// A result never overwrites one that is still waiting
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp.valid || rsp.ready))
		else $error("result committed over a pending result");

	// One item at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("item accepted while another is in progress");

	// Dividers run only for step items
	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> sts.op_step)
		else $error("divider started for a load item");

	// A load never reports congestion
	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !sts.op_step) |=> !rsp.congested)
		else $error("load item flagged congested");
`endif

endmodule
